/* src/ssdsq_pkg.sv */
// ----------------------------------------------------------------------------
// ssdsq_pkg
// Shared constants for the segment-to-segment squared distance core.
// ----------------------------------------------------------------------------
package ssdsq_pkg;

    // Fraction bits of the segment parameters sc and tc.
    localparam int TPAR_BITS = 32;

    // Fraction bits kept in each difference component before squaring.
    localparam int KEEP_BITS = 8;

    // Right shift that rounds a difference component.
    localparam int RND_SHIFT = TPAR_BITS - KEEP_BITS;

    // Latency of the split multiplier.
    localparam int MUL_LAT = 2;

    // Result field and its stream width.
    localparam int DIST_W      = 34;
    localparam int OUT_TDATA_W = 40;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int EPS_W      = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
    localparam logic [APB_ADDR_W-3:0] REG_EPS = 1'b0;

endpackage

/* src/ssdsq_mul.sv */
// ----------------------------------------------------------------------------
// ssdsq_mul
// Two-stage signed multiplier that splits the second operand in halves.
// ----------------------------------------------------------------------------
module ssdsq_mul
    import ssdsq_pkg::*;
#(
    parameter int WIDTH = 36
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [WIDTH-1:0]     op_a,
    input  logic signed [WIDTH-1:0]     op_b,
    output logic signed [2*WIDTH-1:0]   prod
);

    localparam int LO_W = WIDTH / 2;
    localparam int HI_W = WIDTH - LO_W;

    logic signed [WIDTH+LO_W:0]   lo_reg;
    logic signed [WIDTH+LO_W:0]   lo_next;
    logic signed [WIDTH+HI_W-1:0] hi_reg;
    logic signed [WIDTH+HI_W-1:0] hi_next;
    logic signed [2*WIDTH-1:0]    prod_reg;
    logic signed [2*WIDTH-1:0]    prod_next;

    // Partial products against the low and high halves of op_b.
    always_comb
    begin
        lo_next = op_a * $signed({1'b0, op_b[LO_W-1:0]});
        hi_next = op_a * $signed(op_b[WIDTH-1:LO_W]);
    end

    // Recombine the partial products.
    always_comb
    begin
        prod_next = ((2*WIDTH)'(hi_reg) <<< LO_W) + (2*WIDTH)'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* src/ssdsq_div.sv */
// ----------------------------------------------------------------------------
// ssdsq_div
// Pipelined restoring divider, one quotient bit per stage, for 0 <= n <= d.
// ----------------------------------------------------------------------------
module ssdsq_div
    import ssdsq_pkg::*;
#(
    parameter int WIDTH = 74
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [WIDTH-1:0]       num,
    input  logic [WIDTH-1:0]       den,
    output logic [TPAR_BITS:0]     quo
);

    localparam int ITERS = TPAR_BITS + 1;

    logic [WIDTH-1:0] rem_reg [ITERS-1];
    logic [WIDTH-1:0] den_reg [ITERS-1];
    logic [ITERS-1:0] q_reg   [ITERS];

    for (genvar g = 0; g < ITERS; g++)
    begin : g_stage
        logic [WIDTH-1:0] rem_in;
        logic [WIDTH-1:0] den_in;
        logic [ITERS-1:0] q_in;
        logic [WIDTH:0]   shifted;
        logic [WIDTH:0]   diff;
        logic             ge;
        logic [WIDTH-1:0] rem_next;
        logic [ITERS-1:0] q_next;

        // Operands come from the inputs or from the previous stage.
        if (g == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_later
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign q_in   = q_reg[g-1];
        end

        // One compare and subtract step.
        always_comb
        begin
            shifted  = {rem_in, 1'b0};
            diff     = shifted - {1'b0, den_in};
            ge       = (shifted >= {1'b0, den_in});
            rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            q_next   = {q_in[ITERS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[g] <= q_next;
            end
        end

        // The last stage keeps only the quotient.
        if (g < ITERS - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_in;
                end
            end
        end
    end

    assign quo = q_reg[ITERS-1];

endmodule

/* src/segment_segment_distance_sq_core.sv */
// ----------------------------------------------------------------------------
// segment_segment_distance_sq_core
// Squared closest distance between two 3-D segments, fully pipelined.
// ----------------------------------------------------------------------------
// The core takes one segment pair per clock and returns one squared distance
// per pair, in order. Most of the pipeline depth is the 33-stage restoring
// divider that forms the two segment parameters. It sits behind the dot
// product, determinant and clamping stages. While a result waits on m_*,
// the pipeline keeps advancing until the next finished result lands in a
// one-entry skid slot. With that slot full, s_tready falls and every stage
// holds until m_tready empties the output register. Register near_zero_eps
// sits at byte address 0.
// ----------------------------------------------------------------------------
module segment_segment_distance_sq_core
    import ssdsq_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [APB_ADDR_W-1:0]                    paddr,
    input  logic [APB_DATA_W-1:0]                    pwdata,
    output logic [APB_DATA_W-1:0]                    prdata,
    output logic                                     pready,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0 up: a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
    // a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z.
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // Fields from bit 0 up: dist_sq, then zero padding.
    output logic [OUT_TDATA_W-1:0]                   m_tdata
);

    // Widths of the arithmetic.
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int DOTW  = PW + 2;
    localparam int N1    = 2 * DOTW + 1;
    localparam int N2    = DOTW + 2 * FRAC_BITS + 2;
    localparam int N3    = 4 * FRAC_BITS + 2;
    localparam int NA    = (N1 > N2) ? N1 : N2;
    localparam int NW    = ((NA > N3) ? NA : N3) + 1;
    localparam int ITERS = TPAR_BITS + 1;
    localparam int SCW   = TPAR_BITS + 1;
    localparam int PRW   = DW + SCW + 1;
    localparam int XW    = DW + TPAR_BITS + 4;
    localparam int MW    = XW - RND_SHIFT + 1;
    localparam int SQW   = 2 * MW;
    localparam int SA    = SQW + 2;
    localparam int SB    = DIST_W + 2 * KEEP_BITS;
    localparam int SUMW  = (SA > SB) ? SA : SB;
    localparam int SHW   = SUMW - 2 * KEEP_BITS;

    // Pipeline depth.
    localparam int UVW_DLY = 2 + MUL_LAT + 4 + ITERS + 1;
    localparam int LAT     = UVW_DLY + 6;
    localparam int SC_STG  = LAT - 5;

    localparam logic signed [NW-1:0] ONE_S = NW'(1) << (4 * FRAC_BITS);
    localparam logic [SCW-1:0] SC_MAX = SCW'(1) << TPAR_BITS;

    // Component indexes.
    localparam int IU = 0;
    localparam int IV = 1;
    localparam int IW = 2;

    // Dot product indexes.
    localparam int DA = 0;
    localparam int DB = 1;
    localparam int DC = 2;
    localparam int DD = 3;
    localparam int DE = 4;

    logic                  en;
    logic                  push;
    logic [LAT-1:0]        vld_reg;
    logic [EPS_W-1:0]      eps_reg;
    logic                  cfg_we;

    logic signed [CW-1:0]   p_reg     [12];
    logic signed [DW-1:0]   uvw_reg   [3][3];
    logic signed [DW-1:0]   uvwd_reg  [UVW_DLY][3][3];
    logic signed [PW-1:0]   pr_reg    [5][3];
    logic signed [DOTW-1:0] dot_reg   [5];
    logic signed [DOTW-1:0] dotd_reg  [MUL_LAT][5];
    logic signed [2*DOTW-1:0] ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

    logic signed [NW-1:0] det_reg, sn7_reg, tn7_reg;
    logic signed [NW-1:0] as7_reg, bs7_reg, cs7_reg, es7_reg;
    logic signed [NW-1:0] eb7_reg, qn7_reg, qb7_reg;
    logic signed [NW-1:0] sn8_reg, sd8_reg, tn8_reg, td8_reg;
    logic signed [NW-1:0] as8_reg, qn8_reg, qb8_reg;
    logic signed [NW-1:0] sn8_next, sd8_next, tn8_next, td8_next;
    logic signed [NW-1:0] sn9_reg, sd9_reg, tn9_reg, td9_reg;
    logic signed [NW-1:0] sn9_next, sd9_next, tn9_next, td9_next;
    logic [NW-1:0]        ns_reg, ds_reg, nt_reg, dt_reg;
    logic [2*NW-1:0]      pair_s, pair_t;
    logic [ITERS-1:0]     qs, qt;
    logic [ITERS:0]       sc_sum, tc_sum;
    logic [SCW-1:0]       sc_reg, tc_reg;

    logic signed [PRW-1:0] ps_reg [3];
    logic signed [PRW-1:0] pt_reg [3];
    logic signed [DW-1:0]  w45_reg [3];
    logic signed [XW-1:0]  x_reg  [3];
    logic [MW-1:0]         m_reg  [3];
    logic [SQW-1:0]        sq_reg [3];
    logic [SUMW-1:0]       sum_full;
    logic [SHW-1:0]        sum_sh;
    logic [DIST_W-1:0]     dist_next;

    logic                  out_valid_reg, skid_valid_reg;
    logic [DIST_W-1:0]     out_data_reg, skid_data_reg;

    // Magnitude at or below the threshold.
    function automatic logic near_zero(input logic signed [NW-1:0] x,
                                       input logic [EPS_W-1:0] eps);
        logic signed [NW-1:0] mag;
        mag = x[NW-1] ? -x : x;
        return ($unsigned(mag) <= NW'(eps));
    endfunction

    // Maps n and d onto divider operands: n near zero or negative, or d <= 0,
    // gives (0, 1), n >= d gives (1, 1) and a proper fraction passes through.
    function automatic logic [2*NW-1:0] norm_pair(input logic signed [NW-1:0] n,
                                                  input logic signed [NW-1:0] d,
                                                  input logic [EPS_W-1:0] eps);
        logic n_pos;
        logic d_pos;
        n_pos = !n[NW-1] && (n != '0);
        d_pos = !d[NW-1] && (d != '0);
        if (near_zero(n, eps) || !n_pos || !d_pos)
        begin
            return {NW'(0), NW'(1)};
        end
        else if (n >= d)
        begin
            return {NW'(1), NW'(1)};
        end
        return {$unsigned(n), $unsigned(d)};
    endfunction

    // Magnitude rounded to KEEP_BITS parameter fraction bits, halves away.
    function automatic logic [MW-1:0] rnd_mag(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] mag;
        logic [XW:0]          rsum;
        mag  = x[XW-1] ? -x : x;
        rsum = {1'b0, $unsigned(mag)} + ((XW+1)'(1) << (RND_SHIFT - 1));
        return rsum[XW:RND_SHIFT];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_EPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_EPS)
        begin
            prdata = APB_DATA_W'(eps_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves while the skid slot is free.
    // ------------------------------------------------------------------
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Input capture and segment vectors u, v and w.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
            begin
                p_reg[i] <= s_tdata[i*CW +: CW];
            end
            for (int i = 0; i < 3; i++)
            begin
                uvw_reg[IU][i] <= DW'(p_reg[3+i]) - DW'(p_reg[i]);
                uvw_reg[IV][i] <= DW'(p_reg[9+i]) - DW'(p_reg[6+i]);
                uvw_reg[IW][i] <= DW'(p_reg[i]) - DW'(p_reg[6+i]);
            end
        end
    end

    // The vectors wait alongside the arithmetic for the final stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uvwd_reg[0] <= uvw_reg;
            for (int k = 1; k < UVW_DLY; k++)
            begin
                uvwd_reg[k] <= uvwd_reg[k-1];
            end
        end
    end

    // Component products, then the five dot products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[DA][i] <= uvw_reg[IU][i] * uvw_reg[IU][i];
                pr_reg[DB][i] <= uvw_reg[IU][i] * uvw_reg[IV][i];
                pr_reg[DC][i] <= uvw_reg[IV][i] * uvw_reg[IV][i];
                pr_reg[DD][i] <= uvw_reg[IU][i] * uvw_reg[IW][i];
                pr_reg[DE][i] <= uvw_reg[IV][i] * uvw_reg[IW][i];
            end
            for (int j = 0; j < 5; j++)
            begin
                dot_reg[j] <= DOTW'(pr_reg[j][0]) + DOTW'(pr_reg[j][1])
                              + DOTW'(pr_reg[j][2]);
            end
            dotd_reg[0] <= dot_reg;
            for (int k = 1; k < MUL_LAT; k++)
            begin
                dotd_reg[k] <= dotd_reg[k-1];
            end
        end
    end

    // Degree-four products for the determinant and the numerators.
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_ac
        (.clk(clk), .en(en), .op_a(dot_reg[DA]), .op_b(dot_reg[DC]), .prod(ac_p));
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_bb
        (.clk(clk), .en(en), .op_a(dot_reg[DB]), .op_b(dot_reg[DB]), .prod(bb_p));
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_be
        (.clk(clk), .en(en), .op_a(dot_reg[DB]), .op_b(dot_reg[DE]), .prod(be_p));
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_cd
        (.clk(clk), .en(en), .op_a(dot_reg[DC]), .op_b(dot_reg[DD]), .prod(cd_p));
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_ae
        (.clk(clk), .en(en), .op_a(dot_reg[DA]), .op_b(dot_reg[DE]), .prod(ae_p));
    ssdsq_mul #(.WIDTH(DOTW)) u_mul_bd
        (.clk(clk), .en(en), .op_a(dot_reg[DB]), .op_b(dot_reg[DD]), .prod(bd_p));

    // Determinant, raw numerators and the scaled degree-two terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= NW'(ac_p) - NW'(bb_p);
            sn7_reg <= NW'(be_p) - NW'(cd_p);
            tn7_reg <= NW'(ae_p) - NW'(bd_p);
            as7_reg <= NW'(dotd_reg[MUL_LAT-1][DA]) <<< (2 * FRAC_BITS);
            bs7_reg <= NW'(dotd_reg[MUL_LAT-1][DB]) <<< (2 * FRAC_BITS);
            cs7_reg <= NW'(dotd_reg[MUL_LAT-1][DC]) <<< (2 * FRAC_BITS);
            es7_reg <= NW'(dotd_reg[MUL_LAT-1][DE]) <<< (2 * FRAC_BITS);
            eb7_reg <= (NW'(dotd_reg[MUL_LAT-1][DE]) + NW'(dotd_reg[MUL_LAT-1][DB]))
                       <<< (2 * FRAC_BITS);
            qn7_reg <= -(NW'(dotd_reg[MUL_LAT-1][DD]) <<< (2 * FRAC_BITS));
            qb7_reg <= (NW'(dotd_reg[MUL_LAT-1][DB]) - NW'(dotd_reg[MUL_LAT-1][DD]))
                       <<< (2 * FRAC_BITS);
        end
    end

    // First clamp: parallel segments and the range of sc.
    always_comb
    begin
        sd8_next = det_reg;
        td8_next = det_reg;
        sn8_next = sn7_reg;
        tn8_next = tn7_reg;
        if (near_zero(det_reg, eps_reg))
        begin
            sn8_next = '0;
            sd8_next = ONE_S;
            tn8_next = es7_reg;
            td8_next = cs7_reg;
        end
        else if (sn7_reg[NW-1])
        begin
            sn8_next = '0;
            tn8_next = es7_reg;
            td8_next = cs7_reg;
        end
        else if (det_reg < sn7_reg)
        begin
            sn8_next = det_reg;
            tn8_next = eb7_reg;
            td8_next = cs7_reg;
        end
    end

    // Second clamp: the range of tc, with sc recomputed.
    always_comb
    begin
        sn9_next = sn8_reg;
        sd9_next = sd8_reg;
        tn9_next = tn8_reg;
        td9_next = td8_reg;
        if (tn8_reg[NW-1])
        begin
            tn9_next = '0;
            if (qn8_reg[NW-1])
            begin
                sn9_next = '0;
            end
            else if (as8_reg < qn8_reg)
            begin
                sn9_next = sd8_reg;
            end
            else
            begin
                sn9_next = qn8_reg;
                sd9_next = as8_reg;
            end
        end
        else if (td8_reg < tn8_reg)
        begin
            tn9_next = td8_reg;
            if (qb8_reg[NW-1])
            begin
                sn9_next = '0;
            end
            else if (as8_reg < qb8_reg)
            begin
                sn9_next = sd8_reg;
            end
            else
            begin
                sn9_next = qb8_reg;
                sd9_next = as8_reg;
            end
        end
    end

    assign pair_s = norm_pair(sn9_reg, sd9_reg, eps_reg);
    assign pair_t = norm_pair(tn9_reg, td9_reg, eps_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn8_reg <= sn8_next;
            sd8_reg <= sd8_next;
            tn8_reg <= tn8_next;
            td8_reg <= td8_next;
            as8_reg <= as7_reg;
            qn8_reg <= qn7_reg;
            qb8_reg <= qb7_reg;
            sn9_reg <= sn9_next;
            sd9_reg <= sd9_next;
            tn9_reg <= tn9_next;
            td9_reg <= td9_next;
            ns_reg  <= pair_s[2*NW-1:NW];
            ds_reg  <= pair_s[NW-1:0];
            nt_reg  <= pair_t[2*NW-1:NW];
            dt_reg  <= pair_t[NW-1:0];
        end
    end

    // Segment parameters as 33-step fractions.
    ssdsq_div #(.WIDTH(NW)) u_div_s
        (.clk(clk), .en(en), .num(ns_reg), .den(ds_reg), .quo(qs));
    ssdsq_div #(.WIDTH(NW)) u_div_t
        (.clk(clk), .en(en), .num(nt_reg), .den(dt_reg), .quo(qt));

    // Round the extra quotient bit, halves up.
    assign sc_sum = {1'b0, qs} + (ITERS+1)'(1);
    assign tc_sum = {1'b0, qt} + (ITERS+1)'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_sum[ITERS:1];
            tc_reg <= tc_sum[ITERS:1];
        end
    end

    // Closest-point difference vector, rounded magnitude and its square.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ps_reg[i]  <= $signed({1'b0, sc_reg}) * uvwd_reg[UVW_DLY-1][IU][i];
                pt_reg[i]  <= $signed({1'b0, tc_reg}) * uvwd_reg[UVW_DLY-1][IV][i];
                w45_reg[i] <= uvwd_reg[UVW_DLY-1][IW][i];
                x_reg[i]   <= (XW'(w45_reg[i]) <<< TPAR_BITS) + XW'(ps_reg[i])
                              - XW'(pt_reg[i]);
                m_reg[i]   <= rnd_mag(x_reg[i]);
                sq_reg[i]  <= SQW'(m_reg[i]) * SQW'(m_reg[i]);
            end
        end
    end

    // Sum of squares, rounded and saturated.
    always_comb
    begin
        sum_full  = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2])
                    + (SUMW'(1) << (2 * KEEP_BITS - 1));
        sum_sh    = sum_full[SUMW-1:2*KEEP_BITS];
        dist_next = (sum_sh > SHW'(DIST_MAX)) ? DIST_MAX : sum_sh[DIST_W-1:0];
    end

    // ------------------------------------------------------------------
    // Output register with one skid slot.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : dist_next;
        end
        else if (push)
        begin
            skid_data_reg <= dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

`ifndef SYNTHESIS
    // The skid slot only holds a result behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register is empty");

    // The skid slot fills only when the output stalled in the cycle before.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid slot filled without an output stall");

    // Segment parameters never exceed one.
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SC_STG] |-> (sc_reg <= SC_MAX) && (tc_reg <= SC_MAX))
        else $error("segment parameter above one");
`endif

endmodule
